>>> rtl/bvfl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bvfl_pkg
// Shared types, constants and the charge level table of the battery voltage
// filter.
// ----------------------------------------------------------------------------
package bvfl_pkg;

    // Field and register widths.
    localparam int TICK_W     = 16;
    localparam int RAW_W      = 8;
    localparam int VOLT_W     = 16;
    localparam int LEVEL_W    = 7;
    localparam int OFFSET_W   = 10;
    localparam int INTERVAL_W = 16;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    // Register indexes, decoded from paddr[2].
    localparam logic REG_OFFSET   = 1'b0;
    localparam logic REG_INTERVAL = 1'b1;

    // Register reset values.
    localparam logic [OFFSET_W-1:0]   OFFSET_RESET   = 10'd200;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd1;

    // Filter and level mapping constants.
    localparam logic [VOLT_W-1:0]  JUMP_THRESHOLD = 16'd50;
    localparam logic [VOLT_W-1:0]  LEVEL_LOW_V    = 16'd200;
    localparam logic [VOLT_W-1:0]  LEVEL_HIGH_V   = 16'd300;
    localparam logic [LEVEL_W-1:0] LEVEL_FULL     = 7'd100;
    localparam int                 FILTER_SHIFT   = 2;
    localparam int                 ROM_DEPTH      = 100;

    // Control from the sequencer to the filter datapath.
    typedef struct packed {
        logic upd_filter;
        logic upd_level;
        logic sampled;
    } bvfl_ctrl_t;

    // Result of one item as seen by the output register.
    typedef struct packed {
        logic [VOLT_W-1:0]  filtered_voltage;
        logic [LEVEL_W-1:0] charge_level;
        logic               level_changed;
    } bvfl_res_t;

    // Status of the serial remainder unit.
    typedef struct packed {
        logic done;
        logic zero;
    } bvfl_mod_stat_t;

    // Charge level table for voltages from 2.00 V to 2.99 V.
    localparam logic [LEVEL_W-1:0] LEVEL_ROM [ROM_DEPTH] = '{
          7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,
          7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd0,   7'd1,   7'd1,   7'd1,   7'd1,
          7'd1,   7'd1,   7'd1,   7'd1,   7'd2,   7'd2,   7'd2,   7'd2,   7'd3,   7'd3,
          7'd4,   7'd5,   7'd5,   7'd6,   7'd7,   7'd8,   7'd9,   7'd10,  7'd11,  7'd12,
          7'd14,  7'd15,  7'd17,  7'd18,  7'd21,  7'd24,  7'd28,  7'd33,  7'd40,  7'd47,
          7'd54,  7'd64,  7'd72,  7'd76,  7'd78,  7'd80,  7'd82,  7'd83,  7'd85,  7'd86,
          7'd87,  7'd88,  7'd89,  7'd90,  7'd91,  7'd92,  7'd93,  7'd93,  7'd94,  7'd95,
          7'd95,  7'd96,  7'd96,  7'd97,  7'd97,  7'd98,  7'd98,  7'd99,  7'd99,  7'd99,
        7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100,
        7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100, 7'd100
    };

    // Map a filtered voltage to a charge percentage.
    function automatic logic [LEVEL_W-1:0] level_of(input logic [VOLT_W-1:0] v);
        logic [VOLT_W-1:0]  rel;
        logic [LEVEL_W-1:0] idx;
        rel = v - LEVEL_LOW_V;
        idx = rel[LEVEL_W-1:0];
        if (v >= LEVEL_HIGH_V) begin
            level_of = LEVEL_FULL;
        end
        else if (v < LEVEL_LOW_V) begin
            level_of = '0;
        end
        else if (idx >= LEVEL_W'(ROM_DEPTH)) begin
            level_of = LEVEL_FULL;
        end
        else begin
            level_of = LEVEL_ROM[idx];
        end
    endfunction

endpackage
`default_nettype wire

>>> rtl/bvfl_mod.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bvfl_mod
// Bit-serial restoring remainder unit: shifts one dividend bit per cycle into
// a partial remainder and reports whether the final remainder is zero.
// ----------------------------------------------------------------------------
module bvfl_mod (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [bvfl_pkg::TICK_W-1:0]     dividend,
    input  wire logic [bvfl_pkg::INTERVAL_W-1:0] divisor,
    output bvfl_pkg::bvfl_mod_stat_t             stat
);
    import bvfl_pkg::*;

    localparam int CNT_W = $clog2(TICK_W);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [TICK_W-1:0]     dvd_reg, dvd_next;
    logic [INTERVAL_W-1:0] div_reg, div_next;
    logic [INTERVAL_W-1:0] rem_reg, rem_next;
    logic [INTERVAL_W:0]   trial;
    logic [INTERVAL_W:0]   diff;

    // One restoring step: bring down the next dividend bit and subtract.
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[TICK_W-1]};
        diff      = trial - {1'b0, div_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(TICK_W - 1);
            dvd_next  = dividend;
            // An interval of zero counts as one.
            div_next  = (divisor == '0) ? INTERVAL_W'(1) : divisor;
            rem_next  = '0;
        end
        else if (busy_reg) begin
            dvd_next = {dvd_reg[TICK_W-2:0], 1'b0};
            if (diff[INTERVAL_W]) begin
                rem_next = trial[INTERVAL_W-1:0];
            end
            else begin
                rem_next = diff[INTERVAL_W-1:0];
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath shift registers.
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign stat.done = done_reg;
    assign stat.zero = (rem_reg == '0);

endmodule
`default_nettype wire

>>> rtl/bvfl_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bvfl_filter
// Voltage low-pass filter with jump on large steps, and the charge level
// tracker that flags level changes.
// ----------------------------------------------------------------------------
module bvfl_filter (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire bvfl_pkg::bvfl_ctrl_t          ctrl,
    input  wire logic [bvfl_pkg::RAW_W-1:0]    raw,
    input  wire logic [bvfl_pkg::OFFSET_W-1:0] offset,
    output bvfl_pkg::bvfl_res_t                res
);
    import bvfl_pkg::*;

    logic [VOLT_W-1:0]  filter_reg, filter_next;
    logic [LEVEL_W-1:0] last_level_reg, last_level_next;
    logic [VOLT_W-1:0]  sample;
    logic [VOLT_W-1:0]  diff;
    logic [LEVEL_W-1:0] level;
    logic               changed;

    // New filter value from the sample.
    always_comb
    begin
        sample = VOLT_W'(offset) + VOLT_W'(raw);
        diff   = (filter_reg < sample) ? (sample - filter_reg) : (filter_reg - sample);
        filter_next = filter_reg;
        if (ctrl.upd_filter) begin
            if (diff > JUMP_THRESHOLD) begin
                filter_next = sample;
            end
            else begin
                filter_next = filter_reg + (sample >> FILTER_SHIFT)
                              - (filter_reg >> FILTER_SHIFT);
            end
        end
    end

    // Level of the settled filter value.
    always_comb
    begin
        level           = level_of(filter_reg);
        changed         = ctrl.sampled && (level != last_level_reg);
        last_level_next = last_level_reg;
        if (ctrl.upd_level && changed) begin
            last_level_next = level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            filter_reg     <= '0;
            last_level_reg <= '0;
        end
        else begin
            filter_reg     <= filter_next;
            last_level_reg <= last_level_next;
        end
    end

    assign res.filtered_voltage = filter_reg;
    assign res.charge_level     = ctrl.sampled ? level : last_level_reg;
    assign res.level_changed    = changed;

endmodule
`default_nettype wire

>>> rtl/battery_voltage_filter_level.sv
`default_nettype none
// ----------------------------------------------------------------------------
// battery_voltage_filter_level
// Battery voltage sampler with low-pass filter and charge level lookup.
// ----------------------------------------------------------------------------
// Each input item carries a tick number and a raw battery byte and yields one
// result item. The tick-modulo-interval test runs in a bit-serial remainder
// unit at one dividend bit per cycle, followed by a step to report, then by
// the filter update and the level lookup, which also loads the output
// register. An item that takes no sample skips the filter update. The input
// stays stalled while an item is in flight; the next item is accepted once
// the sequencer is back in idle after the result is loaded. A finished result
// waits in the output register while the next item is accepted and worked on;
// that item holds in its level cycle, and the input stays stalled, only while
// the earlier result is still waiting. Registers at byte address 0
// (voltage_offset) and 4 (sample_interval) are written through the APB port;
// the user must write them only while no item is in flight, which the block
// itself does not enforce.
// ----------------------------------------------------------------------------
module battery_voltage_filter_level (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Configuration port.
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [bvfl_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [bvfl_pkg::DATA_W-1:0]     pwdata,
    output logic      [bvfl_pkg::DATA_W-1:0]     prdata,
    output logic                                 pready,
    // Input channel.
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [bvfl_pkg::TICK_W-1:0]     tick_number,
    input  wire logic [bvfl_pkg::RAW_W-1:0]      raw_battery,
    // Output channel.
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 sampled,
    output logic      [bvfl_pkg::VOLT_W-1:0]     filtered_voltage,
    output logic      [bvfl_pkg::LEVEL_W-1:0]    charge_level,
    output logic                                 level_changed
);
    import bvfl_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_FILT  = 2'd2;
    localparam logic [1:0] ST_LEVEL = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [OFFSET_W-1:0]   offset_reg;
    logic [INTERVAL_W-1:0] interval_reg;
    logic [RAW_W-1:0]      raw_reg;
    logic                  sampled_reg, sampled_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_sampled_reg;
    bvfl_res_t             out_res_reg;
    logic                  cfg_write;
    logic                  in_fire;
    logic                  out_free;
    logic                  load_out;
    bvfl_mod_stat_t        mod_stat;
    bvfl_ctrl_t            ctrl;
    bvfl_res_t             res;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            offset_reg   <= OFFSET_RESET;
            interval_reg <= INTERVAL_RESET;
        end
        else if (cfg_write) begin
            case (paddr[2])
                REG_OFFSET:   offset_reg   <= pwdata[OFFSET_W-1:0];
                REG_INTERVAL: interval_reg <= pwdata[INTERVAL_W-1:0];
                default:      offset_reg   <= offset_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_OFFSET:   prdata = DATA_W'(offset_reg);
            REG_INTERVAL: prdata = DATA_W'(interval_reg);
            default:      prdata = '0;
        endcase
    end

    // Sequencer for one item.
    assign in_stall = (state_reg != ST_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign load_out = (state_reg == ST_LEVEL) && out_free;

    always_comb
    begin
        state_next   = state_reg;
        sampled_next = sampled_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (mod_stat.done) begin
                    sampled_next = mod_stat.zero;
                    state_next   = mod_stat.zero ? ST_FILT : ST_LEVEL;
                end
            end
            ST_FILT:
            begin
                state_next = ST_LEVEL;
            end
            ST_LEVEL:
            begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg   <= ST_IDLE;
            sampled_reg <= 1'b0;
        end
        else begin
            state_reg   <= state_next;
            sampled_reg <= sampled_next;
        end
    end

    // Hold the raw byte while the remainder unit works.
    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            raw_reg <= raw_battery;
        end
    end

    bvfl_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_fire),
        .dividend (tick_number),
        .divisor  (interval_reg),
        .stat     (mod_stat)
    );

    assign ctrl.upd_filter = (state_reg == ST_FILT);
    assign ctrl.upd_level  = load_out;
    assign ctrl.sampled    = sampled_reg;

    bvfl_filter u_filter (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .raw    (raw_reg),
        .offset (offset_reg),
        .res    (res)
    );

    // Output register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out) begin
            out_sampled_reg <= sampled_reg;
            out_res_reg     <= res;
        end
    end

    assign out_valid        = out_valid_reg;
    assign sampled          = out_sampled_reg;
    assign filtered_voltage = out_res_reg.filtered_voltage;
    assign charge_level     = out_res_reg.charge_level;
    assign level_changed    = out_res_reg.level_changed;

endmodule
`default_nettype wire
